FILE: design/pidic_pkg.sv
package pidic_pkg;

    // Field and register widths.
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned INDEX_W = 2;

    // Width of the shared multiplier operands and product.
    localparam int unsigned MUL_W  = DATA_W + 1;
    localparam int unsigned PROD_W = 2 * MUL_W;

    // Drive accumulator width: P and I terms reach 2^46, the D term 2^48.
    localparam int unsigned SUM_W = 52;

    // Dividend width for the D term divide and the number of division cycles
    // (two quotient bits per cycle).
    localparam int unsigned DVD_W     = 64;
    localparam int unsigned DIV_STEPS = DVD_W / 2;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    // Register indexes on the configuration port.
    localparam logic [INDEX_W-1:0] REG_P_GAIN         = 2'd0;
    localparam logic [INDEX_W-1:0] REG_I_GAIN         = 2'd1;
    localparam logic [INDEX_W-1:0] REG_D_GAIN         = 2'd2;
    localparam logic [INDEX_W-1:0] REG_INTEGRAL_LIMIT = 2'd3;

    // Integral limit after reset: 1000.0 in Q16.16.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd65536000;

    // Bound on the D term magnitude, 2^48.
    localparam logic [DVD_W-1:0] DTERM_BOUND = 64'h0001_0000_0000_0000;

    // Drive saturation bounds at accumulator width.
    localparam logic signed [SUM_W-1:0] DRIVE_MAX = 52'sh0_0000_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] DRIVE_MIN = -52'sh0_0000_8000_0000;

    typedef logic signed [DATA_W-1:0] q16_t;

endpackage

FILE: design/pid_step_with_integral_clamp_core.sv
// Channel   Handshake                 Beat contents
// -------   -----------------------   ---------------------------------------
// input     in_valid / in_stall       time_step, error_sample
// output    out_valid / out_stall     drive, drive_saturated
// config    cfg_wr_en (no handshake)  cfg_index, cfg_data
//
// One input beat occupies the block from acceptance until in_stall falls again;
// a zero time_step skips the derivative divide, a restoring divider that
// retires two quotient bits per cycle over a 64-bit dividend. The four
// products share one 33 x 33 multiplier.
// Reset is asynchronous and active low; it restores the gains, the limit,
// the integral and the last error. The result sits in an output register, so a
// stalled output holds only the final step of the next beat, not its intake.
module pid_step_with_integral_clamp_core
    import pidic_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [STEP_W-1:0]         time_step,
    input  logic signed [DATA_W-1:0]  error_sample,
    // Output channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  drive,
    output logic                      drive_saturated,
    // Configuration write port
    input  logic                      cfg_wr_en,
    input  logic [INDEX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]         cfg_data
);

    // Sequencer states. INTEG, PTERM and ITERM each consume the product that
    // the previous state launched and launch the next one.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MSTEP = 3'd1; // launch error * step
    localparam logic [2:0] ST_INTEG = 3'd2; // clamp integral; launch P product
    localparam logic [2:0] ST_PTERM = 3'd3; // take P term; launch I product
    localparam logic [2:0] ST_ITERM = 3'd4; // take I term; launch D product
    localparam logic [2:0] ST_DLOAD = 3'd5; // load divider with |D product|
    localparam logic [2:0] ST_DIV   = 3'd6; // two quotient bits per cycle
    localparam logic [2:0] ST_FIN   = 3'd7; // add D term, saturate, present

    logic [2:0]               state_reg, state_next;

    // Configuration and controller state.
    q16_t                     p_gain_reg, i_gain_reg, d_gain_reg;
    logic [LIMIT_W-1:0]       limit_reg;
    q16_t                     integral_reg, integral_next;
    q16_t                     last_error_reg;

    // Captured beat.
    logic [STEP_W-1:0]        step_reg;
    q16_t                     err_reg;

    // Shared multiplier.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;

    // Divider: the dividend register shifts left and collects the quotient.
    logic [DVD_W-1:0]         dvd_reg, dvd_next;
    logic [STEP_W-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;
    logic                     dneg_reg, dneg_next;

    // Drive accumulator.
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    q16_t                     drive_reg, drive_next;
    logic                     sat_reg, sat_next;

    // Combinational helpers.
    logic signed [DATA_W:0]   step_term;
    logic signed [DATA_W+1:0] integ_raw, lim_pos, lim_neg;
    logic signed [SUM_W-1:0]  prod_term;
    logic [PROD_W-1:0]        prod_mag;
    logic [STEP_W:0]          div_r1, div_r2, div_r1_sub, div_r2_sub;
    logic                     div_q1, div_q2;
    logic [STEP_W:0]          div_rem1;
    logic [DVD_W-1:0]         dmag;
    logic signed [SUM_W-1:0]  dterm, total;
    logic                     fin_go;

    assign in_stall        = (state_reg != ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign drive           = drive_reg;
    assign drive_saturated = sat_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MSTEP:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed({{(MUL_W-STEP_W){1'b0}}, step_reg});
            end
            ST_INTEG:
            begin
                mul_a = MUL_W'(p_gain_reg);
                mul_b = MUL_W'(err_reg);
            end
            ST_PTERM:
            begin
                mul_a = MUL_W'(i_gain_reg);
                mul_b = MUL_W'(integral_reg);
            end
            ST_ITERM:
            begin
                // Change in error since the previous beat, 33 bits signed.
                mul_a = MUL_W'(d_gain_reg);
                mul_b = MUL_W'(err_reg) - MUL_W'(last_error_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Integral update: add floor(error * step / 2^16) and clamp to the limit.
    // The product is below 2^47 in magnitude, so bits 48:16 hold the term.
    always_comb
    begin
        step_term = prod_reg[48:16];
        integ_raw = (DATA_W+2)'(integral_reg) + (DATA_W+2)'(step_term);
        lim_pos   = $signed({3'b000, limit_reg});
        lim_neg   = -lim_pos;
        if (integ_raw > lim_pos)
        begin
            integral_next = DATA_W'(lim_pos);
        end
        else if (integ_raw < lim_neg)
        begin
            integral_next = DATA_W'(lim_neg);
        end
        else
        begin
            integral_next = DATA_W'(integ_raw);
        end
    end

    // P and I products are 32 x 32 and fit 64 bits; the arithmetic shift by 16
    // gives the floor that the Q16.16 rescale needs.
    assign prod_term = SUM_W'($signed(prod_reg[63:16]));

    // Magnitude of the D product; it is below 2^63.
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // Two restoring division steps per cycle.
    always_comb
    begin
        div_r1     = {rem_reg, dvd_reg[DVD_W-1]};
        div_r1_sub = div_r1 - {1'b0, step_reg};
        div_q1     = (div_r1 >= {1'b0, step_reg});
        div_rem1   = div_q1 ? div_r1_sub : div_r1;
        div_r2     = {div_rem1[STEP_W-1:0], dvd_reg[DVD_W-2]};
        div_r2_sub = div_r2 - {1'b0, step_reg};
        div_q2     = (div_r2 >= {1'b0, step_reg});
    end

    // D term: clamp the quotient to 2^48 and restore the sign.
    always_comb
    begin
        dmag  = (dvd_reg > DTERM_BOUND) ? DTERM_BOUND : dvd_reg;
        dterm = dneg_reg ? -$signed(SUM_W'(dmag[48:0])) : $signed(SUM_W'(dmag[48:0]));
        total = sum_reg + dterm;
    end

    // A finished result may leave only when the output register is free.
    assign fin_go = !out_valid_reg || !out_stall;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        dneg_next      = dneg_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && out_stall;
        drive_next     = drive_reg;
        sat_next       = sat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MSTEP;
                end
            end
            ST_MSTEP:
            begin
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                state_next = ST_PTERM;
            end
            ST_PTERM:
            begin
                sum_next   = prod_term;
                state_next = ST_ITERM;
            end
            ST_ITERM:
            begin
                sum_next   = sum_reg + prod_term;
                state_next = ST_DLOAD;
            end
            ST_DLOAD:
            begin
                rem_next     = '0;
                div_cnt_next = '0;
                dneg_next    = prod_reg[PROD_W-1];
                if (step_reg == '0)
                begin
                    // A zero step gives no D term.
                    dvd_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    dvd_next   = prod_mag[DVD_W-1:0];
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next     = div_q2 ? div_r2_sub[STEP_W-1:0] : div_r2[STEP_W-1:0];
                dvd_next     = {dvd_reg[DVD_W-3:0], div_q1, div_q2};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    if (total > DRIVE_MAX)
                    begin
                        drive_next = DATA_W'(DRIVE_MAX);
                        sat_next   = 1'b1;
                    end
                    else if (total < DRIVE_MIN)
                    begin
                        drive_next = DATA_W'(DRIVE_MIN);
                        sat_next   = 1'b1;
                    end
                    else
                    begin
                        drive_next = DATA_W'(total);
                        sat_next   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            div_cnt_reg    <= '0;
            p_gain_reg     <= '0;
            i_gain_reg     <= '0;
            d_gain_reg     <= '0;
            limit_reg      <= LIMIT_RESET;
            integral_reg   <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_P_GAIN:         p_gain_reg <= $signed(cfg_data);
                    REG_I_GAIN:         i_gain_reg <= $signed(cfg_data);
                    REG_D_GAIN:         d_gain_reg <= $signed(cfg_data);
                    REG_INTEGRAL_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default:            ;
                endcase
            end
            if (state_reg == ST_INTEG)
            begin
                integral_reg <= integral_next;
            end
            if (state_reg == ST_FIN && fin_go)
            begin
                last_error_reg <= err_reg;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            step_reg <= time_step;
            err_reg  <= error_sample;
        end
        prod_reg  <= mul_a * mul_b;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dneg_reg  <= dneg_next;
        sum_reg   <= sum_next;
        drive_reg <= drive_next;
        sat_reg   <= sat_next;
    end

    // A new result appears only out of the final step.
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result presented outside the final step");

    // The stored integral never exceeds the limit that clamped it.
    a_integral_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PTERM) |->
            ($signed({integral_reg[DATA_W-1], integral_reg}) <= $signed({2'b00, limit_reg}))
            && ($signed({integral_reg[DATA_W-1], integral_reg})
                >= -$signed({2'b00, limit_reg})))
        else $error("integral outside its limit");

    // A saturated drive sits at one of the two range ends.
    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |->
            (drive_reg == DATA_W'(DRIVE_MAX)) || (drive_reg == DATA_W'(DRIVE_MIN)))
        else $error("saturation flag without a clipped drive");

    // The divider runs its full count before the final step.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && $past(state_reg == ST_DIV)) |->
            (div_cnt_reg == '0))
        else $error("divider left before its last step");

endmodule
